[rtl/ccx_pkg.sv]
package ccx_pkg;

  // Fixed limits of the line buffer and of the tab stop spacing
  localparam int unsigned LINE_CAP = 2048;
  localparam int unsigned MAX_TAB  = 16;

  // Field widths
  localparam int COL_W  = 12;
  localparam int POS_W  = 11;
  localparam int TW_W   = 5;
  localparam int CNT_W  = 5;
  localparam int BYTE_W = 8;

  localparam logic [COL_W-1:0] LIM_MAX = COL_W'(LINE_CAP);
  localparam logic [TW_W-1:0]  TAB_MAX = TW_W'(MAX_TAB);

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CARET = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAB_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'b1;

  typedef struct packed {
    logic [TW_W-1:0]  tab_width;
    logic [COL_W-1:0] buffer_size;
  } cfg_t;

  // One command from the classifier to the writer
  typedef struct packed {
    logic              is_end;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] byte0;
    logic [BYTE_W-1:0] byte1;
    logic [COL_W-1:0]  length;
    logic              ff;
  } cmd_t;

endpackage

[rtl/ccx_front.sv]
module ccx_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_text_byte,
  input  logic               in_line_end,
  input  ccx_pkg::cfg_t      cfg,
  output logic               push_valid,
  output ccx_pkg::cmd_t      push_cmd,
  input  logic               q_full
);
  import ccx_pkg::*;

  localparam int BIT_W = $clog2(COL_W);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_EXEC = 4'b0010,
    F_DIV  = 4'b0100,
    F_TAB  = 4'b1000
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              end_r, end_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              ff_r, ff_nxt;
  logic [TW_W-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;

  logic [COL_W-1:0]  lim;
  logic [TW_W-1:0]   tw;
  logic [COL_W-1:0]  room;
  logic              is_ctrl;
  logic              is_tab;
  logic [CNT_W-1:0]  run_n;
  logic [CNT_W-1:0]  kept;
  logic [COL_W:0]    sum;
  logic [COL_W-1:0]  col_adv;
  logic [TW_W:0]     div_t;
  logic [TW_W:0]     div_s;

  // Clamp the configuration to its working range
  assign lim = (cfg.buffer_size > LIM_MAX) ? LIM_MAX : cfg.buffer_size;
  always_comb begin
    if (cfg.tab_width == '0) begin
      tw = TW_W'(1);
    end else if (cfg.tab_width > TAB_MAX) begin
      tw = TAB_MAX;
    end else begin
      tw = cfg.tab_width;
    end
  end

  // Classify the held byte
  assign is_ctrl = (byte_r < CH_SP) && (byte_r != CH_NL);
  assign is_tab  = (byte_r == CH_TAB);

  // Size the run of writes and the column it leaves
  assign room  = lim - col_r;
  assign run_n = (state_r == F_TAB) ? CNT_W'(tw - rem_r)
                                    : (is_ctrl ? CNT_W'(2) : CNT_W'(1));
  assign kept  = (room < COL_W'(run_n)) ? room[CNT_W-1:0] : run_n;
  assign sum   = {1'b0, col_r} + (COL_W+1)'(run_n);
  assign col_adv = (sum > {1'b0, lim}) ? lim : sum[COL_W-1:0];

  // One remainder step: column modulo tab width, one column bit per cycle
  assign div_t = {rem_r, col_r[bit_r]};
  assign div_s = (div_t >= {1'b0, tw}) ? (div_t - {1'b0, tw}) : div_t;

  // Build the command
  always_comb begin
    push_cmd.is_end = end_r;
    push_cmd.pos    = col_r[POS_W-1:0];
    push_cmd.cnt    = kept;
    push_cmd.byte0  = is_tab ? CH_SP : (is_ctrl ? CH_CARET : byte_r);
    push_cmd.byte1  = is_tab ? CH_SP : (byte_r + CH_AT);
    push_cmd.length = end_r ? col_r : '0;
    push_cmd.ff     = end_r & ff_r;
  end

  assign in_ready = (state_r == F_IDLE);

  // Sequence one request
  always_comb begin
    state_nxt  = state_r;
    byte_nxt   = byte_r;
    end_nxt    = end_r;
    col_nxt    = col_r;
    ff_nxt     = ff_r;
    rem_nxt    = rem_r;
    bit_nxt    = bit_r;
    push_valid = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_text_byte;
          end_nxt   = in_line_end;
          state_nxt = F_EXEC;
        end
      end
      F_EXEC: begin
        if (end_r) begin
          if (!q_full) begin
            push_valid = 1'b1;
            col_nxt    = '0;
            ff_nxt     = 1'b0;
            state_nxt  = F_IDLE;
          end
        end else if (col_r >= lim) begin
          state_nxt = F_IDLE;
        end else if ((byte_r == CH_BS) && (col_r != '0)) begin
          col_nxt   = col_r - COL_W'(1);
          state_nxt = F_IDLE;
        end else if (is_tab) begin
          rem_nxt   = '0;
          bit_nxt   = BIT_W'(COL_W - 1);
          state_nxt = F_DIV;
        end else if (!q_full) begin
          push_valid = 1'b1;
          col_nxt    = col_adv;
          if (byte_r == CH_FF) begin
            ff_nxt = 1'b1;
          end
          state_nxt = F_IDLE;
        end
      end
      F_DIV: begin
        rem_nxt = div_s[TW_W-1:0];
        if (bit_r == '0) begin
          state_nxt = F_TAB;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      F_TAB: begin
        if (!q_full) begin
          push_valid = 1'b1;
          col_nxt    = col_adv;
          state_nxt  = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      col_r   <= '0;
      ff_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      ff_r    <= ff_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
  end

endmodule

[rtl/ccx_cmd_fifo.sv]
module ccx_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ccx_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output ccx_pkg::cmd_t dout,
  output logic          empty
);
  import ccx_pkg::*;

  localparam int QPTR_W = $clog2(DEPTH);
  localparam int QCNT_W = $clog2(DEPTH + 1);

  cmd_t              mem_r [DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(DEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(DEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

[rtl/ccx_back.sv]
module ccx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  output logic          q_pop,
  input  ccx_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_write_valid,
  output logic [10:0]   out_write_pos,
  output logic [7:0]    out_write_byte,
  output logic          out_run_last,
  output logic          out_line_done,
  output logic [11:0]   out_line_length,
  output logic          out_form_feed_seen
);
  import ccx_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  bstate_t           state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;

  logic              ov_r, ov_nxt;
  logic              wv_r, wv_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              done_r, done_nxt;
  logic [COL_W-1:0]  len_r, len_nxt;
  logic              ff_r, ff_nxt;

  logic              slot_free;
  logic              is_last;

  assign slot_free = ~ov_r | out_ready;
  assign is_last   = cmd_r.is_end | (k_r == (cmd_r.cnt - CNT_W'(1)));

  // Fetch a command, then emit its results one per cycle while the output register is free
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    q_pop     = 1'b0;
    ov_nxt    = ov_r & ~out_ready;
    wv_nxt    = wv_r;
    pos_nxt   = pos_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    len_nxt   = len_r;
    ff_nxt    = ff_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          k_nxt     = '0;
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          wv_nxt   = ~cmd_r.is_end;
          pos_nxt  = cmd_r.is_end ? '0 : cmd_r.pos + POS_W'(k_r);
          byte_nxt = cmd_r.is_end ? '0 : ((k_r == '0) ? cmd_r.byte0 : cmd_r.byte1);
          last_nxt = is_last;
          done_nxt = cmd_r.is_end;
          len_nxt  = cmd_r.length;
          ff_nxt   = cmd_r.ff;
          if (is_last) begin
            state_nxt = B_IDLE;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    k_r    <= k_nxt;
    wv_r   <= wv_nxt;
    pos_r  <= pos_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
    len_r  <= len_nxt;
    ff_r   <= ff_nxt;
  end

  assign out_valid          = ov_r;
  assign out_write_valid    = wv_r;
  assign out_write_pos      = pos_r;
  assign out_write_byte     = byte_r;
  assign out_run_last       = last_r;
  assign out_line_done      = done_r;
  assign out_line_length    = len_r;
  assign out_form_feed_seen = ff_r;

endmodule

[rtl/control_char_expander.sv]
// Control character expander: tab expansion and caret notation of a text line.
// Input channel (in_*): one request per byte, or a line-end mark. Result
// channel (out_*): positioned writes into an external line buffer, with
// out_run_last on the last result of a request; a line-end request gives one
// summary result carrying the line length and the form-feed flag.
// Configuration port (cfg_*): index 0 is the tab width, index 1 the buffer size;
// write only while no request is in flight.
// Classifier: a request other than a tab passes its accept and classify
// steps; a tab adds a 12-step serial remainder of the column by the tab
// width between classify and the push. It takes no new request before it is
// through with the last. The writer fetches each command, then emits one
// result per cycle while the receiver takes them; the output register holds
// a result until out_ready.
// A queue of QUEUE_DEPTH commands sits between classifier and writer.
// Reset: column and form-feed flag cleared, tab width 8, buffer size 2048,
// queue and output register emptied.
// When the receiver stalls, the result holds in the output register, the
// queue fills, then the classifier holds its next request with in_ready low
// until space frees up.
module control_char_expander #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [10:0] out_write_pos,
  output logic [7:0]  out_write_byte,
  output logic        out_run_last,
  output logic        out_line_done,
  output logic [11:0] out_line_length,
  output logic        out_form_feed_seen,
  input  logic        cfg_we,
  input  logic [ccx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0] cfg_wdata
);
  import ccx_pkg::*;

  logic [TW_W-1:0]  tw_r, tw_nxt;
  logic [COL_W-1:0] bs_r, bs_nxt;
  cfg_t             cfg;

  logic push_valid;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  // Write configuration registers
  always_comb begin
    tw_nxt = tw_r;
    bs_nxt = bs_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TAB_WIDTH:   tw_nxt = cfg_wdata[TW_W-1:0];
        CFG_BUFFER_SIZE: bs_nxt = cfg_wdata[COL_W-1:0];
        default: begin
          tw_nxt = tw_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= TW_W'(8);
      bs_r <= LIM_MAX;
    end else begin
      tw_r <= tw_nxt;
      bs_r <= bs_nxt;
    end
  end

  assign cfg.tab_width   = tw_r;
  assign cfg.buffer_size = bs_r;

  ccx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_line_end  (in_line_end),
    .cfg          (cfg),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  ccx_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push_valid),
    .din   (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .empty (q_empty)
  );

  ccx_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_cmd              (q_cmd),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_write_valid    (out_write_valid),
    .out_write_pos      (out_write_pos),
    .out_write_byte     (out_write_byte),
    .out_run_last       (out_run_last),
    .out_line_done      (out_line_done),
    .out_line_length    (out_line_length),
    .out_form_feed_seen (out_form_feed_seen)
  );

  // No result is shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result either writes a byte or summarizes a line
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_valid != out_line_done))
    else $error("result is neither a write nor a summary, or both");

  // A line summary closes its request
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done) |-> out_run_last)
    else $error("line summary without run_last");

  // The classifier takes one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while the previous one is in work");

endmodule
